>>> design/wfe_pkg.sv
// Wire field encoder package: beat types, type codes, wire types and sizes.
// Shared by wfe_encode and wire_field_encoder_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package wfe_pkg;

  localparam int unsigned MaxBytes    = 15;
  localparam int unsigned TagGroups   = 5;
  localparam int unsigned ValueGroups = 10;

  // Field type codes
  localparam logic [4:0] FT_DOUBLE   = 5'd0;
  localparam logic [4:0] FT_FLOAT    = 5'd1;
  localparam logic [4:0] FT_INT64    = 5'd2;
  localparam logic [4:0] FT_UINT64   = 5'd3;
  localparam logic [4:0] FT_INT32    = 5'd4;
  localparam logic [4:0] FT_UINT32   = 5'd5;
  localparam logic [4:0] FT_ENUM     = 5'd6;
  localparam logic [4:0] FT_BOOL     = 5'd7;
  localparam logic [4:0] FT_SINT32   = 5'd8;
  localparam logic [4:0] FT_SINT64   = 5'd9;
  localparam logic [4:0] FT_FIXED32  = 5'd10;
  localparam logic [4:0] FT_SFIXED32 = 5'd11;
  localparam logic [4:0] FT_FIXED64  = 5'd12;
  localparam logic [4:0] FT_SFIXED64 = 5'd13;
  localparam logic [4:0] FT_BYTES    = 5'd14;
  localparam logic [4:0] FT_MESSAGE  = 5'd15;
  localparam logic [4:0] FT_SGROUP   = 5'd16;
  localparam logic [4:0] FT_EGROUP   = 5'd17;

  // Wire types
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_64BIT  = 3'd1;
  localparam logic [2:0] WT_DELIM  = 3'd2;
  localparam logic [2:0] WT_SGROUP = 3'd3;
  localparam logic [2:0] WT_EGROUP = 3'd4;
  localparam logic [2:0] WT_32BIT  = 3'd5;

  typedef enum logic [1:0] {
    KIND_VARINT = 2'd0,
    KIND_FIX32  = 2'd1,
    KIND_FIX64  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [28:0] field_id;
    logic [4:0]  field_type;
    logic [63:0] field_value;
    logic        omit_tag;
    logic        skip_if_zero;
  } wfe_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } wfe_out_t;

  typedef struct packed {
    logic [3:0]                count;
    logic [MaxBytes-1:0][7:0]  bytes;
  } wfe_enc_t;

endpackage

`default_nettype wire

>>> design/wfe_encode.sv
// Field encoder: turns one registered field into its wire bytes and byte count.
// Pure combinational; uses wfe_pkg types and codes.
`timescale 1ns / 1ps
`default_nettype none

module wfe_encode
  import wfe_pkg::*;
(
  input  wire wfe_in_t item_i,
  output wfe_enc_t     enc_o
);

  logic [63:0] lo32;
  logic [63:0] payload;
  logic [63:0] test;
  logic        test_applies;
  logic        known;
  logic [2:0]  wtype;
  kind_e       kind;
  logic [34:0] tag_val;
  logic [69:0] val_ext;
  logic [2:0]  tag_n;
  logic [3:0]  val_n;
  logic [3:0]  var_n;
  logic [7:0]  tb [TagGroups];
  logic [7:0]  vb [ValueGroups];
  logic [3:0]  j;
  logic        skip;

  assign lo32 = {32'd0, item_i.field_value[31:0]};

  // Type decode
  always_comb begin
    payload      = item_i.field_value;
    test         = item_i.field_value;
    test_applies = 1'b1;
    known        = 1'b1;
    wtype        = WT_VARINT;
    kind         = KIND_VARINT;
    case (item_i.field_type)
      FT_DOUBLE, FT_FIXED64, FT_SFIXED64: begin
        wtype = WT_64BIT;
        kind  = KIND_FIX64;
      end
      FT_FLOAT, FT_FIXED32, FT_SFIXED32: begin
        wtype   = WT_32BIT;
        kind    = KIND_FIX32;
        payload = lo32;
        test    = lo32;
      end
      FT_INT64, FT_UINT64: ;
      FT_INT32, FT_ENUM: begin
        payload = {{32{item_i.field_value[31]}}, item_i.field_value[31:0]};
        test    = lo32;
      end
      FT_UINT32: begin
        payload = lo32;
        test    = lo32;
      end
      FT_BOOL: begin
        test    = {56'd0, item_i.field_value[7:0]};
        payload = {63'd0, (item_i.field_value[7:0] != 8'd0)};
      end
      FT_SINT32: begin
        payload = {32'd0, {item_i.field_value[30:0], 1'b0}
                          ^ {32{item_i.field_value[31]}}};
        test    = lo32;
      end
      FT_SINT64: begin
        payload = {item_i.field_value[62:0], 1'b0} ^ {64{item_i.field_value[63]}};
      end
      FT_BYTES, FT_MESSAGE: begin
        wtype = WT_DELIM;
      end
      FT_SGROUP: begin
        wtype        = WT_SGROUP;
        kind         = KIND_NONE;
        test_applies = 1'b0;
      end
      FT_EGROUP: begin
        wtype        = WT_EGROUP;
        kind         = KIND_NONE;
        test_applies = 1'b0;
      end
      default: begin
        known = 1'b0;
        kind  = KIND_NONE;
      end
    endcase
  end

  assign tag_val = {3'd0, item_i.field_id, wtype};
  assign val_ext = {6'd0, payload};

  // Varint lengths: one plus the index of the highest non-empty 7-bit group; an omitted tag has length zero
  always_comb begin
    tag_n = 3'd1;
    for (int k = 1; k < TagGroups; k++) begin
      if ((tag_val >> (7 * k)) != 35'd0) tag_n = 3'(k + 1);
    end
    if (item_i.omit_tag) tag_n = 3'd0;
    var_n = 4'd1;
    for (int k = 1; k < ValueGroups; k++) begin
      if ((val_ext >> (7 * k)) != 70'd0) var_n = 4'(k + 1);
    end
  end

  always_comb begin
    for (int k = 0; k < TagGroups; k++) begin
      tb[k] = {(3'(k + 1) < tag_n), tag_val[7*k +: 7]};
    end
    for (int k = 0; k < ValueGroups; k++) begin
      vb[k] = {(4'(k + 1) < var_n), val_ext[7*k +: 7]};
    end
    case (kind)
      KIND_FIX32: begin
        val_n = 4'd4;
        for (int k = 0; k < 8; k++) vb[k] = payload[8*k +: 8];
      end
      KIND_FIX64: begin
        val_n = 4'd8;
        for (int k = 0; k < 8; k++) vb[k] = payload[8*k +: 8];
      end
      KIND_NONE: val_n = 4'd0;
      default:   val_n = var_n;
    endcase
  end

  assign skip = !known || (item_i.skip_if_zero && test_applies && (test == 64'd0));

  // Place tag bytes first, then value bytes
  always_comb begin
    enc_o.bytes = '0;
    j           = 4'd0;
    for (int p = 0; p < MaxBytes; p++) begin
      j = 4'(p) - {1'b0, tag_n};
      if ((4'(p) >= {1'b0, tag_n}) && (j < 4'(ValueGroups))) enc_o.bytes[p] = vb[j];
    end
    for (int k = 0; k < TagGroups; k++) begin
      if (3'(k) < tag_n) enc_o.bytes[k] = tb[k];
    end
    enc_o.count = skip ? 4'd0 : ({1'b0, tag_n} + val_n);
  end

endmodule

`default_nettype wire

>>> design/wire_field_encoder_unit.sv
// Wire field encoder top level: input register, encoder, byte shift buffer.
// Uses wfe_pkg and wfe_encode.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one scalar field
//   per beat. Output channel (out_valid_o / out_stall_i / out_data_o) sends the
//   field's wire bytes one beat each, tag first, last_byte set on the final one.
//   A field that encodes to nothing (unknown type, skipped zero, group tag with
//   the tag omitted) gives no output beat.
// Loading: a field accepted into the input register loads into the byte buffer once
//   the buffer is empty or its last byte leaves; its first byte is then offered.
// Throughput: the buffer shifts out one byte per cycle unless out_stall_i is high;
//   a field has up to 15 bytes. The next field loads from the input register as
//   the last byte leaves, so bytes stream with no gaps while that register holds
//   a field that gives bytes; it can take the next field while the buffer drains.
// Reset: clears the input register valid and the byte count; nothing else.
// Output stall: the offered byte holds; in_stall_o is high whenever the input
//   register holds a field that cannot load yet, until the last byte of the
//   buffered field leaves.
`timescale 1ns / 1ps
`default_nettype none

module wire_field_encoder_unit
  import wfe_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire wfe_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output wfe_out_t      out_data_o
);

  wfe_in_t                  item_q;
  logic                     s1_vld_q, s1_vld_d;
  logic [3:0]               cnt_q, cnt_d;
  logic [MaxBytes-1:0][7:0] bytes_q, bytes_d;
  wfe_enc_t                 enc;
  logic                     in_take;
  logic                     out_take;
  logic                     load;

  wfe_encode u_encode (
    .item_i (item_q),
    .enc_o  (enc)
  );

  assign out_valid_o          = (cnt_q != 4'd0);
  assign out_data_o.out_byte  = bytes_q[0];
  assign out_data_o.last_byte = (cnt_q == 4'd1);
  assign out_take             = out_valid_o && !out_stall_i;

  // Load the buffer once it is empty or its last byte leaves this cycle
  assign load       = s1_vld_q && ((cnt_q == 4'd0) || ((cnt_q == 4'd1) && out_take));
  assign in_stall_o = s1_vld_q && !load;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_take)   s1_vld_d = 1'b1;
    else if (load) s1_vld_d = 1'b0;

    cnt_d   = cnt_q;
    bytes_d = bytes_q;
    if (load) begin
      cnt_d   = enc.count;
      bytes_d = enc.bytes;
    end else if (out_take) begin
      cnt_d   = cnt_q - 4'd1;
      bytes_d = {8'd0, bytes_q[MaxBytes-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      cnt_q    <= 4'd0;
    end else begin
      s1_vld_q <= s1_vld_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) item_q <= in_data_i;
    bytes_q <= bytes_d;
  end

`ifndef SYNTHESIS
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_vld_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> cnt_q == $past(enc.count))
    else $error("byte count not taken from encoder on load");

  a_drain_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && (cnt_q > 4'd1)) |=> cnt_q == $past(cnt_q) - 4'd1)
    else $error("byte count did not step down by one");

  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !load) |=> s1_vld_q && $stable(item_q))
    else $error("pending field lost or changed before load");
`endif

endmodule

`default_nettype wire

>>> dv/wire_field_encoder_unit_checker.sv
// Scoreboard for the wire field encoder: watches both channels, predicts wire bytes.
// Depends on wfe_pkg for the beat types, type codes and wire types.
`timescale 1ns / 1ps

module wire_field_encoder_unit_checker
  import wfe_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  wfe_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  wfe_out_t out_data_i,
  output int       mismatches_o,
  output int       bytes_pending_o,
  output int       bytes_checked_o
);

  wfe_out_t   wire_bytes_due[$];
  logic [7:0] field_bytes[$];

  function automatic void append_varint(input logic [63:0] value);
    logic [63:0] rest;
    logic [7:0]  group;
    rest = value;
    do begin
      group = {1'b0, rest[6:0]};
      rest  = rest >> 7;
      if (rest != '0) group[7] = 1'b1;
      if (field_bytes.size() < MaxBytes) field_bytes.push_back(group);
    end while (rest != '0);
  endfunction

  function automatic void append_le(input logic [63:0] value, input int count);
    for (int i = 0; i < count; i++) begin
      if (field_bytes.size() < MaxBytes) field_bytes.push_back(value[8*i +: 8]);
    end
  endfunction

  // Work out the wire bytes of one field and queue them as expected beats.
  function automatic void encode_wire_bytes(input wfe_in_t f);
    logic [63:0] raw;
    logic [63:0] lo32;
    logic [63:0] payload;
    logic [63:0] zero_probe;
    logic [2:0]  wire_kind;
    kind_e       body;
    bit          probed;
    wfe_out_t    beat;
    raw        = f.field_value;
    lo32       = {32'd0, raw[31:0]};
    payload    = '0;
    zero_probe = '0;
    probed     = 1'b1;
    wire_kind  = WT_VARINT;
    body       = KIND_VARINT;
    field_bytes.delete();
    case (f.field_type)
      FT_DOUBLE, FT_FIXED64, FT_SFIXED64: begin
        wire_kind  = WT_64BIT;
        body       = KIND_FIX64;
        payload    = raw;
        zero_probe = raw;
      end
      FT_FLOAT, FT_FIXED32, FT_SFIXED32: begin
        wire_kind  = WT_32BIT;
        body       = KIND_FIX32;
        payload    = lo32;
        zero_probe = lo32;
      end
      FT_INT64, FT_UINT64: begin
        payload    = raw;
        zero_probe = raw;
      end
      FT_INT32, FT_ENUM: begin
        payload    = {{32{raw[31]}}, raw[31:0]};
        zero_probe = lo32;
      end
      FT_UINT32: begin
        payload    = lo32;
        zero_probe = lo32;
      end
      FT_BOOL: begin
        zero_probe = {56'd0, raw[7:0]};
        payload    = (raw[7:0] != 8'd0) ? 64'd1 : 64'd0;
      end
      FT_SINT32: begin
        payload    = {32'd0, {raw[30:0], 1'b0} ^ {32{raw[31]}}};
        zero_probe = lo32;
      end
      FT_SINT64: begin
        payload    = {raw[62:0], 1'b0} ^ {64{raw[63]}};
        zero_probe = raw;
      end
      FT_BYTES, FT_MESSAGE: begin
        wire_kind  = WT_DELIM;
        payload    = raw;
        zero_probe = raw;
      end
      FT_SGROUP: begin
        wire_kind = WT_SGROUP;
        body      = KIND_NONE;
        probed    = 1'b0;
      end
      FT_EGROUP: begin
        wire_kind = WT_EGROUP;
        body      = KIND_NONE;
        probed    = 1'b0;
      end
      default: return;
    endcase

    if (f.skip_if_zero && probed && zero_probe == '0) return;

    if (!f.omit_tag) append_varint({32'd0, f.field_id, wire_kind});
    case (body)
      KIND_VARINT: append_varint(payload);
      KIND_FIX32:  append_le(payload, 4);
      KIND_FIX64:  append_le(payload, 8);
      default:     ;
    endcase

    foreach (field_bytes[i]) begin
      beat.out_byte  = field_bytes[i];
      beat.last_byte = (i == field_bytes.size() - 1);
      wire_bytes_due.push_back(beat);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wfe_out_t due;
    if (!rst_ni) begin
      wire_bytes_due.delete();
      mismatches_o    = 0;
      bytes_pending_o = 0;
      bytes_checked_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) encode_wire_bytes(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (wire_bytes_due.size() == 0) begin
          mismatches_o++;
          $display("%0t: unexpected beat, expected none, got byte 0x%02h last %0b",
                   $time, out_data_i.out_byte, out_data_i.last_byte);
        end else begin
          due = wire_bytes_due.pop_front();
          bytes_checked_o++;
          if (out_data_i.out_byte !== due.out_byte) begin
            mismatches_o++;
            $display("%0t: out_byte mismatch, expected 0x%02h, got 0x%02h",
                     $time, due.out_byte, out_data_i.out_byte);
          end
          if (out_data_i.last_byte !== due.last_byte) begin
            mismatches_o++;
            $display("%0t: last_byte mismatch, expected %0b, got %0b",
                     $time, due.last_byte, out_data_i.last_byte);
          end
        end
      end
      bytes_pending_o = wire_bytes_due.size();
    end
  end

endmodule

>>> dv/wire_field_encoder_unit_test.sv
// Top of the wire field encoder bench: clock, reset, field stimulus and verdict.
// Depends on wfe_pkg, wire_field_encoder_unit and wire_field_encoder_unit_checker.
`timescale 1ns / 1ps

module wire_field_encoder_unit_test;
  import wfe_pkg::*;

  localparam logic [4:0] FT_UNKNOWN_LO = 5'd18;
  localparam logic [4:0] FT_UNKNOWN_HI = 5'd31;
  localparam int         CycleLimit    = 200000;
  localparam int         LongHold      = 80;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  wfe_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  wfe_out_t out_data_o;

  int          mismatches;
  int          bytes_pending;
  int          bytes_checked;
  int          fields_sent  = 0;
  int          cycle_count  = 0;
  int unsigned hold_asks    = 0;
  int unsigned burst_left   = 0;
  wfe_in_t     directed[$];

  wire_field_encoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  wire_field_encoder_unit_checker chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_data_i      (out_data_o),
    .mismatches_o    (mismatches),
    .bytes_pending_o (bytes_pending),
    .bytes_checked_o (bytes_checked)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic wfe_in_t make_field(input logic [28:0] number, input logic [4:0] ftype,
                                         input logic [63:0] value, input bit omit,
                                         input bit skip);
    wfe_in_t f;
    f.field_id     = number;
    f.field_type   = ftype;
    f.field_value  = value;
    f.omit_tag     = omit;
    f.skip_if_zero = skip;
    return f;
  endfunction

  function automatic wfe_in_t random_field();
    wfe_in_t f;
    if ($urandom_range(0, 99) < 8) f.field_type = 5'($urandom_range(FT_UNKNOWN_LO, FT_UNKNOWN_HI));
    else f.field_type = 5'($urandom_range(FT_DOUBLE, FT_EGROUP));
    case ($urandom_range(0, 3))
      0:       f.field_id = 29'($urandom_range(1, 15));
      1:       f.field_id = 29'($urandom_range(16, 2047));
      2:       f.field_id = 29'($urandom);
      default: f.field_id = 29'h1fff_ffff - 29'($urandom_range(0, 3));
    endcase
    case ($urandom_range(0, 7))
      0:       f.field_value = '0;
      1:       f.field_value = 64'($urandom_range(0, 127));
      2:       f.field_value = 64'($urandom_range(128, 16383));
      3:       f.field_value = {$urandom, $urandom};
      4:       f.field_value = 64'd1 << $urandom_range(0, 63);
      5:       f.field_value = '1;
      6:       f.field_value = {32'd0, $urandom};
      default: f.field_value = {$urandom, 32'd0};
    endcase
    f.omit_tag     = ($urandom_range(0, 4) == 0);
    f.skip_if_zero = ($urandom_range(0, 2) == 0);
    return f;
  endfunction

  // Offer one beat from a falling edge; return at the falling edge after it is taken.
  task automatic drive_field(input wfe_in_t f);
    in_data_i  <= f;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    fields_sent++;
    @(negedge clk_i);
  endtask

  // Close a burst with a random gap or none; some gaps are long.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 3);
        2:       gap = $urandom_range(4, 10);
        default: gap = $urandom_range(15, 30);
      endcase
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    wait (bytes_pending == 0);
    @(negedge clk_i);
  endtask

  // Receiver: switch between stall styles; honour long hold-off requests.
  initial begin
    int unsigned style;
    int unsigned style_left;
    int unsigned hold_left;
    int unsigned hold_seen;
    out_stall_i = 1'b0;
    style       = 0;
    style_left  = 0;
    hold_left   = 0;
    hold_seen   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = LongHold;
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(20, 80);
      end
      style_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (style)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 99) < 30);
          2:       out_stall_i <= (style_left % 3 == 0);
          default: out_stall_i <= ($urandom_range(0, 99) < 70);
        endcase
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;

    // longest field: five-byte tag and ten-byte value
    directed.push_back(make_field(29'h1fff_ffff, FT_UINT64, '1, 1'b0, 1'b0));
    directed.push_back(make_field(29'd1, FT_INT32, 64'h0000_0000_8000_0000, 1'b0, 1'b0));
    directed.push_back(make_field(29'd2, FT_ENUM, 64'h0000_0000_ffff_ffff, 1'b0, 1'b1));
    directed.push_back(make_field(29'd3, FT_INT64, '0, 1'b0, 1'b1));
    directed.push_back(make_field(29'd3, FT_INT64, '0, 1'b0, 1'b0));
    directed.push_back(make_field(29'd4, FT_UINT32, 64'hffff_ffff_0000_0000, 1'b0, 1'b1));
    directed.push_back(make_field(29'd4, FT_UINT32, 64'hdead_beef_0000_0080, 1'b1, 1'b0));
    // bool: only the low byte counts, any nonzero sends 1
    directed.push_back(make_field(29'd5, FT_BOOL, 64'h0000_0000_0000_0100, 1'b0, 1'b1));
    directed.push_back(make_field(29'd5, FT_BOOL, 64'h0000_0000_0000_005a, 1'b0, 1'b1));
    directed.push_back(make_field(29'd6, FT_SINT32, 64'h0000_0000_ffff_ffff, 1'b0, 1'b0));
    directed.push_back(make_field(29'd6, FT_SINT32, 64'h1234_5678_7fff_ffff, 1'b0, 1'b0));
    directed.push_back(make_field(29'd7, FT_SINT64, 64'h8000_0000_0000_0000, 1'b0, 1'b0));
    directed.push_back(make_field(29'd7, FT_SINT64, 64'h7fff_ffff_ffff_ffff, 1'b1, 1'b0));
    // negative zero floats still go out under skip
    directed.push_back(make_field(29'd8, FT_FLOAT, 64'h0000_0000_8000_0000, 1'b0, 1'b1));
    directed.push_back(make_field(29'd8, FT_DOUBLE, 64'h8000_0000_0000_0000, 1'b0, 1'b1));
    directed.push_back(make_field(29'd9, FT_FIXED32, 64'hffff_ffff_0102_0304, 1'b0, 1'b0));
    directed.push_back(make_field(29'd9, FT_SFIXED32, 64'h0000_0000_ffff_fffe, 1'b1, 1'b0));
    directed.push_back(make_field(29'd10, FT_FIXED64, 64'h0102_0304_0506_0708, 1'b0, 1'b0));
    directed.push_back(make_field(29'd10, FT_SFIXED64, '1, 1'b0, 1'b1));
    directed.push_back(make_field(29'd15, FT_BYTES, '0, 1'b0, 1'b1));
    directed.push_back(make_field(29'd16, FT_MESSAGE, 64'd300, 1'b0, 1'b0));
    // group tags ignore skip and value; with the tag omitted nothing is sent
    directed.push_back(make_field(29'd17, FT_SGROUP, '0, 1'b0, 1'b1));
    directed.push_back(make_field(29'd17, FT_EGROUP, '1, 1'b1, 1'b0));
    directed.push_back(make_field(29'd0, FT_EGROUP, '0, 1'b0, 1'b0));
    directed.push_back(make_field(29'd20, FT_UNKNOWN_LO, '1, 1'b0, 1'b0));
    directed.push_back(make_field(29'd21, FT_UNKNOWN_HI, 64'd1, 1'b0, 1'b0));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      pace_sender();
      drive_field(directed[i]);
    end
    drain_outputs();

    // Hold the receiver off while a back-to-back burst backs up into the input.
    hold_asks++;
    repeat (16) drive_field(random_field());
    drain_outputs();

    for (int n = 0; n < 110; n++) begin
      if (n == 55) drain_outputs();
      pace_sender();
      drive_field(random_field());
    end
    in_valid_i <= 1'b0;

    wait (bytes_pending == 0);
    repeat (10) @(posedge clk_i);

    $display("Encoded %0d fields (%0d directed, the rest random) under bursty input",
             fields_sent, directed.size());
    $display("and varied output stalls; %0d wire bytes compared", bytes_checked);
    if (mismatches == 0 && bytes_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
